[hdl/fkrs_pkg.sv]
// Package for the Fenwick k-th remaining select block.
// Holds the action codes, the walk engine opcodes, state types and reset values.
// No dependencies.
package fkrs_pkg;

    localparam int TREE_SIZE_DEF = 1024;
    localparam int ACTION_W      = 2;
    localparam int INDEX_W       = 10;
    localparam int AMOUNT_W      = 12;
    localparam int RANK_W        = 10;
    localparam int COUNT_W       = 32;
    localparam int POS_W         = 11;

    localparam logic [POS_W-1:0] PIN_RESET = 11'd1024;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_SELECT = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        EOP_ADD,
        EOP_PREFIX,
        EOP_CLEAR
    } t_eng_op;

    typedef enum logic [1:0] {
        E_IDLE,
        E_ADD,
        E_PREFIX,
        E_CLEAR
    } t_eng_state;

    typedef enum logic [2:0] {
        T_INIT,
        T_INIT_WAIT,
        T_IDLE,
        T_RUN_WAIT,
        T_SEL_TEST,
        T_SEL_WAIT,
        T_FIN
    } t_top_state;

    typedef struct packed {
        logic    start;
        t_eng_op op;
    } t_eng_req;

endpackage

[hdl/fkrs_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fkrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/fkrs_tree.sv]
// Fenwick tree walk engine: add walk, prefix walk and clearing sweep over the count RAM.
// Depends on fkrs_pkg and fkrs_ram.
module fkrs_tree
    import fkrs_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEF,
    parameter int IW        = $clog2(TREE_SIZE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_eng_req           i_req,
    input  logic [IW-1:0]      i_idx,
    input  logic [COUNT_W-1:0] i_amt,
    output logic               o_done,
    output logic [COUNT_W-1:0] o_sum
);

    localparam logic [IW:0] TS      = (IW + 1)'(TREE_SIZE);
    localparam logic [IW:0] TS_LAST = (IW + 1)'(TREE_SIZE - 1);

    t_eng_state         r_state, n_state;
    logic [IW:0]        r_i, n_i;
    logic               r_first, n_first;
    logic               r_go, n_go;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_waddr, n_waddr;
    logic [COUNT_W-1:0] r_sum, n_sum;
    logic [COUNT_W-1:0] r_amt, n_amt;
    logic               r_done, n_done;

    logic [IW:0]        lowbit;
    logic               we;
    logic [IW-1:0]      waddr;
    logic [COUNT_W-1:0] wdata;
    logic [IW-1:0]      raddr;
    logic [COUNT_W-1:0] rdata;

    fkrs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TREE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign lowbit = r_i & ((~r_i) + {{IW{1'b0}}, 1'b1});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
        r_i     <= n_i;
        r_first <= n_first;
        r_go    <= n_go;
        r_waddr <= n_waddr;
        r_sum   <= n_sum;
        r_amt   <= n_amt;
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_first = r_first;
        n_go    = r_go;
        n_pend  = 1'b0;
        n_waddr = r_waddr;
        n_sum   = r_sum;
        n_amt   = r_amt;
        n_done  = 1'b0;
        raddr   = '0;
        we      = 1'b0;
        waddr   = r_waddr;
        wdata   = rdata + r_amt;
        unique case (r_state)
            E_IDLE: begin
                if (i_req.start) begin
                    n_i     = {1'b0, i_idx};
                    n_amt   = i_amt;
                    n_sum   = '0;
                    n_first = 1'b1;
                    n_go    = 1'b1;
                    unique case (i_req.op)
                        EOP_ADD:    n_state = E_ADD;
                        EOP_PREFIX: n_state = E_PREFIX;
                        EOP_CLEAR: begin
                            n_i     = '0;
                            n_state = E_CLEAR;
                        end
                        default:    n_state = E_IDLE;
                    endcase
                end
            end
            E_ADD: begin
                // Write back the cell read in the previous cycle. Walk addresses only
                // grow, so the read issued now never hits the cell being written.
                we = r_pend;
                if (r_go && (r_i < TS)) begin
                    raddr   = r_i[IW-1:0];
                    n_pend  = 1'b1;
                    n_waddr = r_i[IW-1:0];
                    n_i     = r_i + lowbit;
                    if (r_i == '0) begin
                        n_go = 1'b0;
                    end
                end else if (!r_pend) begin
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            E_PREFIX: begin
                if (r_pend) begin
                    n_sum = r_sum + rdata;
                end
                if (r_first) begin
                    raddr   = '0;
                    n_pend  = 1'b1;
                    n_first = 1'b0;
                end else if (r_i != '0) begin
                    raddr  = r_i[IW-1:0];
                    n_pend = 1'b1;
                    n_i    = r_i - lowbit;
                end else if (!r_pend) begin
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            E_CLEAR: begin
                we    = 1'b1;
                waddr = r_i[IW-1:0];
                wdata = '0;
                n_i   = r_i + {{IW{1'b0}}, 1'b1};
                if (r_i == TS_LAST) begin
                    n_done  = 1'b1;
                    n_state = E_IDLE;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

[hdl/fenwick_kth_remaining_select_top.sv]
// Top level of the Fenwick k-th remaining select block: handshakes, configuration,
// binary-search select controller and output register. Depends on fkrs_pkg, fkrs_tree.
//
// Usage. Each input word carries an action (add, prefix query, select, clear) with
// index, amount and rank; it is accepted when i_valid and o_ready are both high.
// Every input word produces exactly one output word (o_prefix_count, o_position),
// offered on o_valid and taken when i_ready is high. Non-query actions report a
// prefix count of zero, non-select actions a position of zero.
// Operation. One word is worked on at a time in one RAM with a registered read. An add
// does one read-modify-write per cycle along its upward walk. A query sums cell 0 and
// the cells on the downward walk of its index. A select takes about
// log2(positions_in_use) + 1 search steps, each a prefix query of the probed position.
// A clear sweeps the RAM one entry per cycle.
// Reset. After i_rst_n is released a clearing sweep runs, and o_ready first rises
// when the sweep ends; positions_in_use resets to 1024. Configuration writes
// (i_cfg_we, i_cfg_data) are taken in any cycle.
// Stalls. The output register holds a finished word while i_ready is low; the next
// input word is still accepted and worked on, and waits until the register is free.
module fenwick_kth_remaining_select_top
    import fkrs_pkg::*;
#(
    parameter int TREE_SIZE = TREE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [ACTION_W-1:0]        i_action,
    input  logic [INDEX_W-1:0]         i_index,
    input  logic signed [AMOUNT_W-1:0] i_amount,
    input  logic [RANK_W-1:0]          i_rank,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COUNT_W-1:0]  o_prefix_count,
    output logic [POS_W-1:0]           o_position,
    input  logic                       i_cfg_we,
    input  logic [POS_W-1:0]           i_cfg_data
);

    localparam int IW = $clog2(TREE_SIZE);

    t_top_state          r_state, n_state;
    logic [POS_W-1:0]    r_pin;
    t_action             r_act, n_act;
    logic [RANK_W-1:0]   r_rank, n_rank;
    logic signed [12:0]  r_lo, n_lo;
    logic signed [12:0]  r_hi, n_hi;
    logic [11:0]         r_mid, n_mid;
    logic [COUNT_W-1:0]  r_res_prefix, n_res_prefix;
    logic [POS_W-1:0]    r_res_pos, n_res_pos;
    logic                r_ovalid, n_ovalid;
    logic [COUNT_W-1:0]  r_oprefix, n_oprefix;
    logic [POS_W-1:0]    r_opos, n_opos;

    t_eng_req            eng_req;
    logic [IW-1:0]       eng_idx;
    logic [COUNT_W-1:0]  eng_amt;
    logic                eng_done;
    logic [COUNT_W-1:0]  eng_sum;

    logic                in_acc;
    t_action             in_act;
    logic [31:0]         idx32;
    logic [31:0]         idx_clamped;
    logic [31:0]         n32;
    logic [12:0]         lohi_sum;
    logic [11:0]         mid_now;
    logic [31:0]         mid32;
    logic [COUNT_W-1:0]  below;
    logic                hit;

    fkrs_tree #(
        .TREE_SIZE (TREE_SIZE),
        .IW        (IW)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .i_idx   (eng_idx),
        .i_amt   (eng_amt),
        .o_done  (eng_done),
        .o_sum   (eng_sum)
    );

    assign o_ready = (r_state == T_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign in_act  = t_action'(i_action);
    assign eng_amt = {{(COUNT_W - AMOUNT_W){i_amount[AMOUNT_W-1]}}, i_amount};

    // Indexes past the end of the store fall onto the last cell.
    assign idx32       = {{(32 - INDEX_W){1'b0}}, i_index};
    assign idx_clamped = (idx32 >= 32'(TREE_SIZE)) ? 32'(TREE_SIZE - 1) : idx32;

    // Search bound: positions_in_use, limited to the store size.
    assign n32 = ({{(32 - POS_W){1'b0}}, r_pin} > 32'(TREE_SIZE)) ?
                 32'(TREE_SIZE) : {{(32 - POS_W){1'b0}}, r_pin};

    // Both bounds are non-negative whenever a search step is taken.
    assign lohi_sum = r_lo + r_hi;
    assign mid_now  = lohi_sum[12:1];
    assign mid32    = {20'b0, mid_now};

    // mid less the prefix count through mid (positions 0 to mid), compared in 32-bit two's complement.
    assign below = {20'b0, r_mid} - eng_sum;
    assign hit   = $signed({{(COUNT_W - RANK_W){1'b0}}, r_rank}) <= $signed(below);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_INIT;
            r_pin    <= PIN_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_pin <= i_cfg_data;
            end
        end
        r_act        <= n_act;
        r_rank       <= n_rank;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_res_prefix <= n_res_prefix;
        r_res_pos    <= n_res_pos;
        r_oprefix    <= n_oprefix;
        r_opos       <= n_opos;
    end

    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_rank       = r_rank;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_res_prefix = r_res_prefix;
        n_res_pos    = r_res_pos;
        n_ovalid     = r_ovalid && !i_ready;
        n_oprefix    = r_oprefix;
        n_opos       = r_opos;
        eng_req      = '{start: 1'b0, op: EOP_CLEAR};
        eng_idx      = idx_clamped[IW-1:0];
        unique case (r_state)
            T_INIT: begin
                eng_req = '{start: 1'b1, op: EOP_CLEAR};
                n_state = T_INIT_WAIT;
            end
            T_INIT_WAIT: begin
                if (eng_done) begin
                    n_state = T_IDLE;
                end
            end
            T_IDLE: begin
                if (in_acc) begin
                    n_act        = in_act;
                    n_rank       = i_rank;
                    n_res_prefix = '0;
                    n_res_pos    = '0;
                    n_lo         = '0;
                    n_hi         = $signed(n32[12:0]) - 13'sd1;
                    unique case (in_act)
                        ACT_ADD: begin
                            eng_req = '{start: 1'b1, op: EOP_ADD};
                            n_state = T_RUN_WAIT;
                        end
                        ACT_QUERY: begin
                            eng_req = '{start: 1'b1, op: EOP_PREFIX};
                            n_state = T_RUN_WAIT;
                        end
                        ACT_SELECT: begin
                            n_state = T_SEL_TEST;
                        end
                        ACT_CLEAR: begin
                            eng_req = '{start: 1'b1, op: EOP_CLEAR};
                            n_state = T_RUN_WAIT;
                        end
                        default: n_state = T_IDLE;
                    endcase
                end
            end
            T_RUN_WAIT: begin
                if (eng_done) begin
                    if (r_act == ACT_QUERY) begin
                        n_res_prefix = eng_sum;
                    end
                    n_state = T_FIN;
                end
            end
            T_SEL_TEST: begin
                if (r_lo <= r_hi) begin
                    eng_req = '{start: 1'b1, op: EOP_PREFIX};
                    eng_idx = mid32[IW-1:0];
                    n_mid   = mid_now;
                    n_state = T_SEL_WAIT;
                end else begin
                    n_res_pos = POS_W'(r_hi + 13'sd1);
                    n_state   = T_FIN;
                end
            end
            T_SEL_WAIT: begin
                if (eng_done) begin
                    if (hit) begin
                        n_hi = $signed({1'b0, r_mid}) - 13'sd1;
                    end else begin
                        n_lo = $signed({1'b0, r_mid}) + 13'sd1;
                    end
                    n_state = T_SEL_TEST;
                end
            end
            T_FIN: begin
                // Move the result into the output register once it is free.
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_oprefix = r_res_prefix;
                    n_opos    = r_res_pos;
                    n_state   = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_prefix_count = $signed(r_oprefix);
    assign o_position     = r_opos;

endmodule
